/* hw/rtl/utf8_stream_validator_macros.svh */
// Assertion macros for the UTF-8 stream validator.
`ifndef UTF8_STREAM_VALIDATOR_MACROS_SVH
`define UTF8_STREAM_VALIDATOR_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define UTF8SV_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked outside reset.
`define UTF8SV_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* hw/rtl/utf8sv_pkg.sv */
// Types, constants and helpers shared by the UTF-8 stream validator.
package utf8sv_pkg;

   localparam int CP_WIDTH = 22;

   localparam logic [7:0] CONT_MASK     = 8'hC0;
   localparam logic [7:0] CONT_TAG      = 8'h80;
   localparam logic [7:0] LEAD_TWO_MIN  = 8'hC2;
   localparam logic [7:0] LEAD_THREE    = 8'hE0;
   localparam logic [7:0] LEAD_FOUR     = 8'hF0;
   localparam logic [CP_WIDTH-1:0] SURROGATE_LO = 22'h00D800;
   localparam logic [CP_WIDTH-1:0] SURROGATE_HI = 22'h00DFFF;
   localparam logic [CP_WIDTH-1:0] CP_MAX       = 22'h10FFFF;

   typedef enum logic [1:0] {
      STATUS_CONTINUE = 2'd0,
      STATUS_VALID    = 2'd1,
      STATUS_INVALID  = 2'd2,
      STATUS_SKIPPED  = 2'd3
   } status_type;

   typedef struct packed {
      logic [1:0]          bytes_expected;
      logic [7:0]          lead_byte;
      logic [CP_WIDTH-1:0] partial_code_point;
      logic                skipping;
   } state_type;

   function automatic logic [1:0] continuations(input logic [7:0] lead);
      logic [1:0] count;
      if (lead >= LEAD_FOUR) begin
         count = 2'd3;
      end else if (lead >= LEAD_THREE) begin
         count = 2'd2;
      end else begin
         count = 2'd1;
      end
      return count;
   endfunction

endpackage

/* hw/rtl/utf8_stream_validator.sv */
// UTF-8 stream validator top level: input register, decode, result register.
// The accepted byte waits in the input register until it advances; its status is
// then offered from the result register.
// Throughput: one byte per cycle; the input register advances whenever the
// result register is empty or its status is being taken.
// Reset (synchronous, active high): both registers empty, lead position,
// not skipping.
`include "utf8_stream_validator_macros.svh"

module utf8_stream_validator (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_byte_value,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [1:0] rsp_status
);

   logic                   in_valid_ff;
   logic                   in_valid_in;
   logic [7:0]             in_byte_ff;
   logic                   out_valid_ff;
   logic                   out_valid_in;
   utf8sv_pkg::status_type status_ff;
   utf8sv_pkg::state_type  state_ff;
   utf8sv_pkg::state_type  state_in;
   utf8sv_pkg::status_type status_in;
   logic                   advance;

   utf8sv_step u_step (
      .state      (state_ff),
      .byte_value (in_byte_ff),
      .state_next (state_in),
      .status     (status_in)
   );

   assign advance      = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready    = !in_valid_ff || advance;
   assign in_valid_in  = (req_valid && req_ready) || (in_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff     <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (advance) begin
            state_ff <= state_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_byte_ff <= req_byte_value;
      end
      if (advance) begin
         status_ff <= status_in;
      end
   end

   assign rsp_valid  = out_valid_ff;
   assign rsp_status = status_ff;

   `UTF8SV_ASSERT_NEXT(a_skip_reports_skipped, clock, reset, advance && state_ff.skipping, rsp_valid && (rsp_status == utf8sv_pkg::STATUS_SKIPPED), "skipping item not reported as skipped")
   `UTF8SV_ASSERT_NOW(a_pending_has_lead, clock, reset, state_ff.bytes_expected != 2'd0, state_ff.lead_byte[7], "continuation due without a lead byte")
   `UTF8SV_ASSERT_NOW(a_skip_at_lead, clock, reset, state_ff.skipping, state_ff.bytes_expected == 2'd0, "skipping while a sequence is open")
   `UTF8SV_ASSERT_NOW(a_stall_holds_item, clock, reset, !req_ready, in_valid_ff && out_valid_ff && !rsp_ready, "input stalled without a held item")

endmodule

/* hw/rtl/utf8sv_step.sv */
// Per-byte decode: next sequence state and status for one item.
module utf8sv_step (
   input  utf8sv_pkg::state_type  state,
   input  logic [7:0]             byte_value,
   output utf8sv_pkg::state_type  state_next,
   output utf8sv_pkg::status_type status
);

   logic [1:0]                      total;
   logic                            second;
   logic                            is_cont;
   logic [utf8sv_pkg::CP_WIDTH-1:0] shifted;
   logic [1:0]                      expected_dec;
   utf8sv_pkg::state_type           reject_state;

   assign total        = utf8sv_pkg::continuations(state.lead_byte);
   assign second       = (state.bytes_expected == total);
   assign is_cont      = ((byte_value & utf8sv_pkg::CONT_MASK) == utf8sv_pkg::CONT_TAG);
   assign shifted      = {state.partial_code_point[utf8sv_pkg::CP_WIDTH-7:0], byte_value[5:0]};
   assign expected_dec = state.bytes_expected - 2'd1;

   always_comb begin
      reject_state          = '0;
      reject_state.skipping = (byte_value != 8'd0);
   end

   always_comb begin
      state_next = state;
      status     = utf8sv_pkg::STATUS_CONTINUE;
      priority if (state.skipping) begin
         if (byte_value == 8'd0) begin
            state_next.skipping = 1'b0;
         end
         status = utf8sv_pkg::STATUS_SKIPPED;
      end else if (state.bytes_expected == 2'd0) begin
         if (!byte_value[7]) begin
            status = (byte_value == 8'd0) ? utf8sv_pkg::STATUS_VALID
                                           : utf8sv_pkg::STATUS_CONTINUE;
         end else begin
            state_next.lead_byte          = byte_value;
            state_next.bytes_expected     = utf8sv_pkg::continuations(byte_value);
            state_next.partial_code_point = {18'd0, byte_value[3:0]};
         end
      end else if (!is_cont || (second && (state.lead_byte < utf8sv_pkg::LEAD_TWO_MIN))) begin
         state_next = reject_state;
         status     = utf8sv_pkg::STATUS_INVALID;
      end else begin
         state_next.partial_code_point = shifted;
         state_next.bytes_expected     = expected_dec;
         if (expected_dec == 2'd0) begin
            if (((total == 2'd2) && (shifted >= utf8sv_pkg::SURROGATE_LO)
                 && (shifted <= utf8sv_pkg::SURROGATE_HI))
                || ((total == 2'd3) && (shifted > utf8sv_pkg::CP_MAX))) begin
               state_next = reject_state;
               status     = utf8sv_pkg::STATUS_INVALID;
            end else begin
               state_next.lead_byte          = 8'd0;
               state_next.partial_code_point = '0;
            end
         end
      end
   end

endmodule
